// ----- design/kww_pkg.sv -----
// Shared constants, status and action codes for the keyed wait/wake table.
// No dependencies.
package kww_pkg;

   localparam int ENTRIES_DEF          = 16;
   localparam int WAITERS_PER_ENTRY_DEF = 4;
   localparam int KEY_BITS_DEF         = 48;
   localparam int WAITER_ID_BITS_DEF   = 12;

   localparam int GEN_BITS = 32;

   localparam logic [2:0] ST_DONE    = 3'd0;
   localparam logic [2:0] ST_PARKED  = 3'd1;
   localparam logic [2:0] ST_BADKEY  = 3'd2;
   localparam logic [2:0] ST_NOSPACE = 3'd3;
   localparam logic [2:0] ST_WOKEN   = 3'd4;

   localparam logic [1:0] ACT_WAIT   = 2'd0;
   localparam logic [1:0] ACT_WAKE   = 2'd1;
   localparam logic [1:0] ACT_FINISH = 2'd2;
   localparam logic [1:0] ACT_NONE   = 2'd3;

endpackage

// ----- design/kww_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kww_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- design/keyed_wait_wake_table_top.sv -----
// Keyed wait/wake table: key search, credit/generation logic, waiter FIFOs.
// Depends on kww_pkg and kww_ram.
//
//  channel  dir  handshake          payload
//  req_     in   req_valid/ready    action, key, mode, expected, waiter, wake_limit
//  rsp_     out  rsp_valid/ready    status, woken_waiter, last
//
// One item at a time. The key search walks the entry RAM, reading and then
// comparing each entry in turn; after the decision state, a wake or finish
// walks the entry's waiter FIFO, with one read and one check per parked
// waiter, before the write-back. Items with key zero, action three or a wait
// with waiter zero skip the search and go straight to the response.
// Reset is synchronous and clears only control state and the in-use bits.
// A stalled rsp_ beat holds the sequencer wherever it next needs the output.
module keyed_wait_wake_table_top
   import kww_pkg::*;
#(
   parameter int ENTRIES           = ENTRIES_DEF,
   parameter int WAITERS_PER_ENTRY = WAITERS_PER_ENTRY_DEF,
   parameter int KEY_BITS          = KEY_BITS_DEF,
   parameter int WAITER_ID_BITS    = WAITER_ID_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_action,
   input  logic [KEY_BITS-1:0]       req_key,
   input  logic                      req_mode,
   input  logic [GEN_BITS-1:0]       req_expected,
   input  logic [WAITER_ID_BITS-1:0] req_waiter,
   input  logic [2:0]                req_wake_limit,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                rsp_status,
   output logic [WAITER_ID_BITS-1:0] rsp_woken_waiter,
   output logic                      rsp_last
);

   localparam int EB = $clog2(ENTRIES);
   localparam int CW = $clog2(WAITERS_PER_ENTRY + 1);
   localparam int FD = ENTRIES * WAITERS_PER_ENTRY;
   localparam int FA = (FD > 1) ? $clog2(FD) : 1;
   localparam int EW = KEY_BITS + 1 + GEN_BITS + CW;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_DECIDE, S_FIFO_RD, S_FIFO_CHK, S_FINAL, S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic [1:0]                act_ff, act_in;
   logic [KEY_BITS-1:0]       key_ff, key_in;
   logic                      mode_ff, mode_in;
   logic [GEN_BITS-1:0]       exp_ff, exp_in;
   logic [WAITER_ID_BITS-1:0] wid_ff, wid_in;
   logic [2:0]                lim_ff, lim_in;
   logic [EB:0]               scan_ff, scan_in;
   logic                      found_ff, found_in;
   logic                      free_ok_ff, free_ok_in;
   logic [EB-1:0]             free_ff, free_in;
   logic [EB-1:0]             e_ff, e_in;
   logic                      credit_ff, credit_in;
   logic [GEN_BITS-1:0]       gen_ff, gen_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [CW-1:0]             k_ff, k_in;
   logic [CW-1:0]             j_ff, j_in;
   logic                      matched_ff, matched_in;
   logic                      tail_ff, tail_in;
   logic [2:0]                tail_st_ff, tail_st_in;
   logic                      used_ff [ENTRIES];
   logic                      used_in [ENTRIES];
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [2:0]                rsp_status_ff, rsp_status_in;
   logic [WAITER_ID_BITS-1:0] rsp_wid_ff, rsp_wid_in;
   logic                      rsp_last_ff, rsp_last_in;

   // entry RAM: {key, credit, generation, waiter count}
   logic          ent_we;
   logic [EW-1:0] ent_wdata, ent_rdata;
   logic [WAITER_ID_BITS-1:0] fifo_wdata, fifo_rdata;
   logic          fifo_we;
   logic [FA-1:0] fifo_waddr, fifo_raddr;

   logic [KEY_BITS-1:0] rd_key;
   logic                rd_credit;
   logic [GEN_BITS-1:0] rd_gen;
   logic [CW-1:0]       rd_cnt;
   logic                slot_free;
   logic [EB-1:0]       scan_idx;
   logic [EB-1:0]       e_sel;
   logic [CW-1:0]       maxn;
   logic                last_j;
   logic                match_now;

   assign {rd_key, rd_credit, rd_gen, rd_cnt} = ent_rdata;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign scan_idx  = scan_ff[EB-1:0];
   assign ent_wdata = {key_ff, credit_ff, gen_ff, cnt_ff};
   assign fifo_raddr = FA'(int'(e_ff) * WAITERS_PER_ENTRY + int'(j_ff));
   assign last_j    = (j_ff == cnt_ff - CW'(1));
   assign match_now = !matched_ff && (fifo_rdata == wid_ff);

   always_comb begin
      if (lim_ff == 3'd0 || 32'(lim_ff) > WAITERS_PER_ENTRY) begin
         maxn = CW'(WAITERS_PER_ENTRY);
      end else begin
         maxn = CW'(lim_ff);
      end
   end

   kww_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ent_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (e_ff),
      .wr_data (ent_wdata),
      .rd_addr (scan_idx),
      .rd_data (ent_rdata)
   );

   kww_ram #(.WIDTH(WAITER_ID_BITS), .DEPTH(FD)) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (fifo_waddr),
      .wr_data (fifo_wdata),
      .rd_addr (fifo_raddr),
      .rd_data (fifo_rdata)
   );

   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      key_in      = key_ff;
      mode_in     = mode_ff;
      exp_in      = exp_ff;
      wid_in      = wid_ff;
      lim_in      = lim_ff;
      scan_in     = scan_ff;
      found_in    = found_ff;
      free_ok_in  = free_ok_ff;
      free_in     = free_ff;
      e_in        = e_ff;
      credit_in   = credit_ff;
      gen_in      = gen_ff;
      cnt_in      = cnt_ff;
      k_in        = k_ff;
      j_in        = j_ff;
      matched_in  = matched_ff;
      tail_in     = tail_ff;
      tail_st_in  = tail_st_ff;
      used_in     = used_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_wid_in    = rsp_wid_ff;
      rsp_last_in   = rsp_last_ff;
      ent_we      = 1'b0;
      fifo_we     = 1'b0;
      fifo_waddr  = fifo_raddr;
      fifo_wdata  = fifo_rdata;
      e_sel       = found_ff ? e_ff : free_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in     = req_action;
               key_in     = req_key;
               mode_in    = req_mode;
               exp_in     = req_expected;
               wid_in     = req_waiter;
               lim_in     = req_wake_limit;
               scan_in    = '0;
               found_in   = 1'b0;
               free_ok_in = 1'b0;
               matched_in = 1'b0;
               j_in       = '0;
               if (req_action == ACT_NONE) begin
                  tail_st_in = ST_DONE;
                  state_in   = S_EMIT;
               end else if (req_key == '0) begin
                  tail_st_in = ST_BADKEY;
                  state_in   = S_EMIT;
               end else if (req_action == ACT_WAIT && req_waiter == '0) begin
                  tail_st_in = ST_NOSPACE;
                  state_in   = S_EMIT;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (used_ff[scan_idx] && rd_key == key_ff) begin
               found_in  = 1'b1;
               e_in      = scan_idx;
               credit_in = rd_credit;
               gen_in    = rd_gen;
               cnt_in    = rd_cnt;
               state_in  = S_DECIDE;
            end else begin
               if (!used_ff[scan_idx] && !free_ok_ff) begin
                  free_ok_in = 1'b1;
                  free_in    = scan_idx;
               end
               if (scan_ff == (EB+1)'(ENTRIES - 1)) begin
                  state_in = S_DECIDE;
               end else begin
                  scan_in  = scan_ff + (EB+1)'(1);
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_DECIDE: begin
            e_in    = e_sel;
            tail_in = 1'b1;
            j_in    = '0;
            case (act_ff)
               ACT_WAIT: begin
                  if (mode_ff && found_ff && gen_ff != exp_ff) begin
                     tail_st_in = ST_DONE;
                     state_in   = S_FINAL;
                  end else if (mode_ff && !found_ff && exp_ff != '0) begin
                     tail_st_in = ST_DONE;
                     state_in   = S_EMIT;
                  end else if (!mode_ff && found_ff && credit_ff) begin
                     credit_in  = 1'b0;
                     tail_st_in = ST_DONE;
                     state_in   = S_FINAL;
                  end else if (!found_ff && !free_ok_ff) begin
                     tail_st_in = ST_NOSPACE;
                     state_in   = S_EMIT;
                  end else if (found_ff && 32'(cnt_ff) >= WAITERS_PER_ENTRY) begin
                     tail_st_in = ST_NOSPACE;
                     state_in   = S_FINAL;
                  end else begin
                     // park: fresh entry starts empty with no credit
                     fifo_we    = 1'b1;
                     fifo_waddr = FA'(int'(e_sel) * WAITERS_PER_ENTRY
                                      + int'(found_ff ? cnt_ff : CW'(0)));
                     fifo_wdata = wid_ff;
                     if (!found_ff) begin
                        credit_in = 1'b0;
                        gen_in    = '0;
                        cnt_in    = CW'(1);
                     end else begin
                        cnt_in = cnt_ff + CW'(1);
                     end
                     tail_st_in = ST_PARKED;
                     state_in   = S_FINAL;
                  end
               end
               ACT_WAKE: begin
                  tail_st_in = ST_DONE;
                  if (found_ff) begin
                     gen_in = gen_ff + GEN_BITS'(1);
                     k_in   = (cnt_ff < maxn) ? cnt_ff : maxn;
                     if (cnt_ff < maxn && !mode_ff) begin
                        credit_in = 1'b1;
                     end
                     if (cnt_ff != '0) begin
                        tail_in  = 1'b0;
                        state_in = S_FIFO_RD;
                     end else begin
                        state_in = S_FINAL;
                     end
                  end else if (mode_ff) begin
                     state_in = S_EMIT;
                  end else if (!free_ok_ff) begin
                     tail_st_in = ST_NOSPACE;
                     state_in   = S_EMIT;
                  end else begin
                     gen_in    = GEN_BITS'(1);
                     credit_in = 1'b1;
                     cnt_in    = '0;
                     state_in  = S_FINAL;
                  end
               end
               default: begin
                  // finish
                  tail_st_in = ST_DONE;
                  if (!found_ff) begin
                     state_in = S_EMIT;
                  end else if (cnt_ff != '0) begin
                     state_in = S_FIFO_RD;
                  end else begin
                     state_in = S_FINAL;
                  end
               end
            endcase
         end
         S_FIFO_RD: begin
            state_in = S_FIFO_CHK;
         end
         S_FIFO_CHK: begin
            if (act_ff == ACT_WAKE) begin
               if (j_ff < k_ff) begin
                  if (slot_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_WOKEN;
                     rsp_wid_in    = fifo_rdata;
                     rsp_last_in   = (j_ff == k_ff - CW'(1));
                     j_in          = j_ff + CW'(1);
                  end
               end else begin
                  fifo_we    = 1'b1;
                  fifo_waddr = FA'(int'(e_ff) * WAITERS_PER_ENTRY + int'(j_ff - k_ff));
                  j_in       = j_ff + CW'(1);
               end
            end else begin
               if (matched_ff) begin
                  fifo_we    = 1'b1;
                  fifo_waddr = FA'(int'(e_ff) * WAITERS_PER_ENTRY + int'(j_ff) - 1);
               end
               if (match_now) begin
                  matched_in = 1'b1;
               end
               j_in = j_ff + CW'(1);
            end
            if (j_in != j_ff) begin
               if (last_j) begin
                  if (act_ff == ACT_WAKE) begin
                     cnt_in = cnt_ff - k_ff;
                  end else if (matched_ff || match_now) begin
                     cnt_in = cnt_ff - CW'(1);
                  end
                  state_in = S_FINAL;
               end else begin
                  state_in = S_FIFO_RD;
               end
            end
         end
         S_FINAL: begin
            ent_we        = 1'b1;
            used_in[e_ff] = !(cnt_ff == '0 && !credit_ff);
            state_in      = tail_ff ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = tail_st_ff;
               rsp_wid_in    = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            used_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
      end
      act_ff        <= act_in;
      key_ff        <= key_in;
      mode_ff       <= mode_in;
      exp_ff        <= exp_in;
      wid_ff        <= wid_in;
      lim_ff        <= lim_in;
      scan_ff       <= scan_in;
      found_ff      <= found_in;
      free_ok_ff    <= free_ok_in;
      free_ff       <= free_in;
      e_ff          <= e_in;
      credit_ff     <= credit_in;
      gen_ff        <= gen_in;
      cnt_ff        <= cnt_in;
      k_ff          <= k_in;
      j_ff          <= j_in;
      matched_ff    <= matched_in;
      tail_ff       <= tail_in;
      tail_st_ff    <= tail_st_in;
      rsp_status_ff <= rsp_status_in;
      rsp_wid_ff    <= rsp_wid_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_woken_waiter = rsp_wid_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef ASSERT_OFF
   a_wid_only_woken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_WOKEN |-> rsp_woken_waiter == '0)
      else $error("woken id on a non-wake beat");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a second item while busy");
   a_park_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_WOKEN |-> rsp_last)
      else $error("single-result status without last");
   a_fifo_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIFO_CHK |-> j_ff < cnt_ff)
      else $error("FIFO walk ran past the waiter count");
`endif

endmodule
